/* sv/dtd_pkg.sv */
// Shared types and constants for the double tap detector.
package dtd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE           = 3'd0,
    PH_FIRST_PRESSED  = 3'd1,
    PH_FIRST_RELEASED = 3'd2,
    PH_SECOND_PRESSED = 3'd3,
    PH_ABORT          = 3'd4
  } phase_t;

  // bit 0 left good, bit 1 right good, bit 2 left foul, bit 3 right foul
  typedef logic [3:0] flags_t;

  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned TIME_W    = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MIN_TAP = 2'd0;
  localparam cfg_idx_t CFG_MAX_TAP = 2'd1;
  localparam cfg_idx_t CFG_MAX_GAP = 2'd2;

  localparam logic [CFG_W-1:0] MIN_TAP_RST = 24'd5000;
  localparam logic [CFG_W-1:0] MAX_TAP_RST = 24'd500000;
  localparam logic [CFG_W-1:0] MAX_GAP_RST = 24'd400000;

  typedef struct packed {
    logic   double_tap;
    flags_t hits;
  } result_t;

endpackage

/* sv/double_tap_detector.sv */
// Double tap detector top level: tap state machine, config registers, output skid.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | four contact flags, time_us
//   out_    | output    | out_valid/out_stall| double_tap, four hit flags
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle while in_stall is low; the state registers load at the
// accepting edge, and the result loads into the output register or the skid stage.
// The output register plus a one-entry skid stage decouple the two sides;
// in_stall rises only when both hold a result.
// rst_n is synchronous; it clears the phase, the result valids and the config
// registers to their defaults. cfg_ready is always high.
module double_tap_detector
  import dtd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_left_good,
  input  logic                 in_right_good,
  input  logic                 in_left_foul,
  input  logic                 in_right_foul,
  input  logic [TIME_W-1:0]    in_time_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_double_tap,
  output logic                 out_hit_left_good,
  output logic                 out_hit_right_good,
  output logic                 out_hit_left_foul,
  output logic                 out_hit_right_foul,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfg_idx_t             cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]  min_tap_r, max_tap_r, max_gap_r;
  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic [TIME_W-1:0] release_start_r, release_start_nxt;
  flags_t            first_flags_r, first_flags_nxt;
  flags_t            second_flags_r, second_flags_nxt;
  result_t           res;
  result_t           out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  flags_t            flags;
  logic              any;
  logic [TIME_W-1:0] held, gap;
  logic              accept, pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign pop       = out_valid_r && !out_stall;

  assign flags = {in_right_foul, in_left_foul, in_right_good, in_left_good};
  assign any   = |flags;
  assign held  = in_time_us - press_start_r;
  assign gap   = in_time_us - release_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_tap_r <= MIN_TAP_RST;
      max_tap_r <= MAX_TAP_RST;
      max_gap_r <= MAX_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_TAP: min_tap_r <= cfg_data;
        CFG_MAX_TAP: max_tap_r <= cfg_data;
        CFG_MAX_GAP: max_gap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    press_start_nxt   = press_start_r;
    release_start_nxt = release_start_r;
    first_flags_nxt   = first_flags_r;
    second_flags_nxt  = second_flags_r;
    res               = '0;
    case (phase_r)
      PH_FIRST_PRESSED: begin
        if (held > {8'd0, max_tap_r}) begin
          phase_nxt = PH_ABORT;
        end else if (!any) begin
          if (held >= {8'd0, min_tap_r}) begin
            release_start_nxt = in_time_us;
            phase_nxt         = PH_FIRST_RELEASED;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_FIRST_RELEASED: begin
        if (gap > {8'd0, max_gap_r}) begin
          phase_nxt = PH_IDLE;
        end else if (any) begin
          press_start_nxt  = in_time_us;
          second_flags_nxt = flags;
          phase_nxt        = PH_SECOND_PRESSED;
        end
      end
      PH_SECOND_PRESSED: begin
        if (held > {8'd0, max_tap_r}) begin
          phase_nxt = PH_ABORT;
        end else if (!any) begin
          if (held >= {8'd0, min_tap_r}) begin
            res.double_tap = 1'b1;
            res.hits       = first_flags_r | second_flags_r;
          end
          phase_nxt = PH_IDLE;
        end
      end
      PH_ABORT: begin
        if (!any) phase_nxt = PH_IDLE;
      end
      default: begin
        if (any) begin
          press_start_nxt = in_time_us;
          first_flags_nxt = flags;
          phase_nxt       = PH_FIRST_PRESSED;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      press_start_r   <= '0;
      release_start_r <= '0;
      first_flags_r   <= '0;
      second_flags_r  <= '0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      press_start_r   <= press_start_nxt;
      release_start_r <= release_start_nxt;
      first_flags_r   <= first_flags_nxt;
      second_flags_r  <= second_flags_nxt;
    end
  end

  // output register with one-entry skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_double_tap     = out_r.double_tap;
  assign out_hit_left_good  = out_r.hits[0];
  assign out_hit_right_good = out_r.hits[1];
  assign out_hit_left_foul  = out_r.hits[2];
  assign out_hit_right_foul = out_r.hits[3];

endmodule

/* sv/dtd_checker.sv */
// Port-level checker for the double tap detector, bound to the top level.
module dtd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_double_tap,
  input logic out_hit_left_good,
  input logic out_hit_right_good,
  input logic out_hit_left_foul,
  input logic out_hit_right_foul
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result channel not empty after reset");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_no_tap_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_double_tap |-> !out_hit_left_good && !out_hit_right_good
      && !out_hit_left_foul && !out_hit_right_foul)
    else $error("hit flags set without a double tap");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_double_tap)
      && $stable(out_hit_left_good) && $stable(out_hit_right_good)
      && $stable(out_hit_left_foul) && $stable(out_hit_right_foul))
    else $error("stalled result changed");

endmodule

bind double_tap_detector dtd_checker u_dtd_checker (.*);
